// ===== design/sdpi_pkg.sv =====
package sdpi_pkg;

	typedef logic signed [63:0] fx_t;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_NEG = 3'd4;

	typedef struct packed {
		logic       start;
		logic [2:0] op;
		fx_t        a;
		fx_t        b;
	} alu_req_t;

	typedef struct packed {
		logic done;
		fx_t  res;
		logic sat;
	} alu_rsp_t;

	localparam logic signed [63:0] S64MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64MIN = 64'sh8000_0000_0000_0000;

endpackage

// ===== design/sdpi_if.sv =====
interface sdpi_in_if;
	logic        valid;
	logic        ready;
	logic [62:0] diffusivity;
	logic [63:0] energy;
	logic [63:0] gradient;
	logic        is_last;
	modport source (output valid, diffusivity, energy, gradient, is_last, input ready);
	modport sink (input valid, diffusivity, energy, gradient, is_last, output ready);
endinterface

interface sdpi_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] concentration;
	logic [63:0] drag;
	logic        done_res;
	logic        overflow;
	modport source (output valid, concentration, drag, done_res, overflow, input ready);
	modport sink (input valid, concentration, drag, done_res, overflow, output ready);
endinterface

// ===== design/sdpi_alu.sv =====
module sdpi_alu #(
	parameter int FRAC_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sdpi_pkg::alu_req_t req,
	output sdpi_pkg::alu_rsp_t rsp
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_PACK = 3'd3;

	logic [2:0]    state_q;
	logic [2:0]    op_q;
	logic          neg_q;
	logic [63:0]   ma_q;
	logic [63:0]   mb_q;
	logic [127:0]  acc_q;
	logic [63:0]   rem_q;
	logic [6:0]    cnt_q;
	logic [63:0]   ma;
	logic [63:0]   mb;
	logic [64:0]   rem_sh;
	logic [64:0]   rem_sub;
	logic          qbit;
	logic [127:0]  num;
	logic [127:0]  shifted;
	logic [79:0]   part;
	logic [127:0]  pack_m;
	logic [63:0]   sum;
	logic          ovf;
	sdpi_pkg::fx_t res_c;
	logic          sat_c;

	assign ma = req.a[63] ? (64'd0 - req.a) : req.a;
	assign mb = req.b[63] ? (64'd0 - req.b) : req.b;
	assign num = {64'd0, ma_q} << FRAC_BITS;
	assign rem_sh = {rem_q, num[7'd127 - cnt_q]};
	assign rem_sub = rem_sh - {1'b0, mb_q};
	assign qbit = !rem_sub[64];
	assign shifted = acc_q >> FRAC_BITS;
	assign part = {64'd0, ma_q[15:0]} * {16'd0, mb_q};
	assign pack_m = (op_q == sdpi_pkg::OP_MUL) ? shifted : acc_q;

	always_comb begin
		sum = req.a + req.b;
		ovf = 1'b0;
		res_c = '0;
		sat_c = 1'b0;
		unique case (req.op)
			sdpi_pkg::OP_ADD: begin
				sum = req.a + req.b;
				ovf = (req.a[63] == req.b[63]) && (sum[63] != req.a[63]);
			end
			sdpi_pkg::OP_SUB: begin
				sum = req.a - req.b;
				ovf = (req.a[63] != req.b[63]) && (sum[63] != req.a[63]);
			end
			default: begin
				sum = 64'd0 - req.a;
				ovf = (req.a == sdpi_pkg::S64MIN);
			end
		endcase
		if (ovf) begin
			sat_c = 1'b1;
			res_c = (req.op == sdpi_pkg::OP_NEG) ? sdpi_pkg::S64MAX :
				(req.a[63] ? sdpi_pkg::S64MIN : sdpi_pkg::S64MAX);
		end else begin
			res_c = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= '0;
			neg_q <= 1'b0;
			ma_q <= '0;
			mb_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			rsp.done <= 1'b0;
			rsp.sat <= 1'b0;
			rsp.res <= '0;
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						ma_q <= ma;
						mb_q <= (req.op == sdpi_pkg::OP_DIV) ? req.b : mb;
						neg_q <= (req.op == sdpi_pkg::OP_DIV) ? req.a[63] :
							(req.a[63] ^ req.b[63]);
						acc_q <= '0;
						rem_q <= '0;
						cnt_q <= '0;
						priority if (req.op == sdpi_pkg::OP_MUL) begin
							state_q <= ST_MUL;
						end else if (req.op == sdpi_pkg::OP_DIV) begin
							if (req.b == 64'd0) begin
								rsp.done <= 1'b1;
								rsp.sat <= 1'b1;
								rsp.res <= req.a[63] ? sdpi_pkg::S64MIN : sdpi_pkg::S64MAX;
							end else begin
								state_q <= ST_DIV;
							end
						end else begin
							rsp.done <= 1'b1;
							rsp.res <= res_c;
							rsp.sat <= sat_c;
						end
					end
				end
				ST_MUL: begin
					acc_q <= acc_q + ({48'd0, part} << {cnt_q[1:0], 4'd0});
					ma_q <= ma_q >> 16;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[1:0] == 2'd3) begin
						state_q <= ST_PACK;
					end
				end
				ST_DIV: begin
					rem_q <= qbit ? rem_sub[63:0] : rem_sh[63:0];
					acc_q <= {acc_q[126:0], qbit};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) begin
						state_q <= ST_PACK;
					end
				end
				ST_PACK: begin
					state_q <= ST_IDLE;
					rsp.done <= 1'b1;
					if (neg_q) begin
						rsp.sat <= (pack_m > 128'h8000_0000_0000_0000);
						rsp.res <= (pack_m > 128'h8000_0000_0000_0000) ? sdpi_pkg::S64MIN :
							64'd0 - pack_m[63:0];
					end else begin
						rsp.sat <= (pack_m > 128'h7FFF_FFFF_FFFF_FFFF);
						rsp.res <= (pack_m > 128'h7FFF_FFFF_FFFF_FFFF) ? sdpi_pkg::S64MAX :
							pack_m[63:0];
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/solute_drag_profile_integrator_core.sv =====
// Work per word: segments 0 and 1 start the program at step 19; from segment 2 on it
// runs from step 0, with two divides (a zero divisor saturates without the divide
// loop), multiplies and adds on the shared ALU.
// Flow: one word at a time; the next word is taken only after the result word
// has been accepted by the output.
// Reset: asynchronous active low; registers and profile state clear to zero.
module solute_drag_profile_integrator_core #(
	parameter int FRAC_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	sdpi_in_if.sink           in_ch,
	sdpi_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [5:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	localparam logic [2:0] REG_VEL  = 3'd0;
	localparam logic [2:0] REG_WID  = 3'd1;
	localparam logic [2:0] REG_BULK = 3'd2;
	localparam logic [2:0] REG_C0   = 3'd3;
	localparam logic [2:0] REG_C1   = 3'd4;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	sdpi_pkg::fx_t vel_q, bulk_q, c0_q, c1_q;
	logic [62:0]   wid_q;
	sdpi_pkg::fx_t e1_q, e2_q, c1b_q, c2b_q, sum_q;
	logic [62:0]   d1_q, d2_q;
	logic [1:0]    phase_q;
	logic          ovf_q;
	logic [1:0]    state_q;
	logic [4:0]    step_q;
	logic          sat_q;
	sdpi_pkg::fx_t r_q [0:7];
	logic [62:0]   d_in_q;
	sdpi_pkg::fx_t e_in_q, g_in_q;
	logic          last_in_q;
	sdpi_pkg::fx_t conc_q, drag_q;
	logic [2:0]    widx;
	logic          wen;

	sdpi_pkg::alu_req_t req;
	sdpi_pkg::alu_rsp_t rsp;
	logic               skip;

	sdpi_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	assign pready = 1'b1;
	assign widx = paddr[5:3];
	assign wen = psel && penable && pwrite && pready;

	always_comb begin
		unique case (widx)
			REG_VEL: prdata = vel_q;
			REG_WID: prdata = {1'b0, wid_q};
			REG_BULK: prdata = bulk_q;
			REG_C0: prdata = c0_q;
			REG_C1: prdata = c1_q;
			default: prdata = '0;
		endcase
	end

	// program: r[] scratch; fields op, a, b, dest
	always_comb begin
		req.start = 1'b0;
		req.op = sdpi_pkg::OP_ADD;
		req.a = '0;
		req.b = '0;
		skip = 1'b0;
		unique case (step_q)
			5'd0: begin req.op = sdpi_pkg::OP_DIV; req.a = {1'b0, d2_q}; req.b = {1'b0, d1_q}; end
			5'd1: begin req.op = sdpi_pkg::OP_SUB; req.a = 64'sd1 <<< FRAC_BITS; req.b = r_q[0]; end
			5'd2: begin req.op = sdpi_pkg::OP_SUB; req.a = e1_q; req.b = e2_q; end
			5'd3: begin req.op = sdpi_pkg::OP_MUL; req.a = vel_q; req.b = {1'b0, wid_q}; end
			5'd4: begin req.op = sdpi_pkg::OP_DIV; req.a = r_q[2]; req.b = {1'b0, d1_q}; end
			5'd5: begin req.op = sdpi_pkg::OP_SUB; req.a = c1b_q; req.b = c2b_q; end
			5'd6: begin req.op = sdpi_pkg::OP_ADD; req.a = r_q[0]; req.b = r_q[1]; end
			5'd7: begin req.op = sdpi_pkg::OP_ADD; req.a = r_q[4]; req.b = r_q[2]; end
			5'd8: begin req.op = sdpi_pkg::OP_MUL; req.a = r_q[3]; req.b = r_q[4]; end
			5'd9: begin req.op = sdpi_pkg::OP_MUL; req.a = r_q[0]; req.b = r_q[1]; end
			5'd10: begin req.op = sdpi_pkg::OP_ADD; req.a = r_q[5]; req.b = e_in_q; end
			5'd11: begin req.op = sdpi_pkg::OP_ADD; req.a = r_q[5]; req.b = e2_q; end
			5'd12: begin req.op = sdpi_pkg::OP_ADD; req.a = e1_q; req.b = e1_q; end
			5'd13: begin req.op = sdpi_pkg::OP_SUB; req.a = r_q[5]; req.b = r_q[6]; end
			5'd14: begin req.op = sdpi_pkg::OP_MUL; req.a = c1b_q; req.b = r_q[5]; end
			5'd15: begin req.op = sdpi_pkg::OP_ADD; req.a = c1b_q; req.b = c1b_q; end
			5'd16: begin req.op = sdpi_pkg::OP_SUB; req.a = r_q[6]; req.b = c2b_q; end
			5'd17: begin req.op = sdpi_pkg::OP_ADD; req.a = r_q[4]; req.b = r_q[5]; end
			5'd18: begin req.op = sdpi_pkg::OP_SUB; req.a = r_q[6]; req.b = r_q[4]; end
			5'd19: begin
				req.op = sdpi_pkg::OP_SUB; req.a = conc_q; req.b = bulk_q;
				skip = (phase_q == 2'd0) || last_in_q;
			end
			5'd20: begin
				req.op = sdpi_pkg::OP_MUL; req.a = g_in_q; req.b = r_q[7];
				skip = (phase_q == 2'd0) || last_in_q;
			end
			5'd21: begin
				req.op = sdpi_pkg::OP_ADD; req.a = sum_q; req.b = r_q[7];
				skip = (phase_q == 2'd0) || last_in_q;
			end
			5'd22: begin req.op = sdpi_pkg::OP_MUL; req.a = {1'b0, wid_q}; req.b = sum_q; skip = !last_in_q; end
			5'd23: begin req.op = sdpi_pkg::OP_NEG; req.a = r_q[7]; skip = !last_in_q; end
			default: skip = 1'b1;
		endcase
		req.start = (state_q == S_RUN) && !skip;
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.concentration = conc_q;
	assign out_ch.drag = drag_q;
	assign out_ch.done_res = last_in_q;
	assign out_ch.overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q <= '0; wid_q <= '0; bulk_q <= '0; c0_q <= '0; c1_q <= '0;
			e1_q <= '0; e2_q <= '0; c1b_q <= '0; c2b_q <= '0; sum_q <= '0;
			d1_q <= '0; d2_q <= '0; phase_q <= '0; ovf_q <= 1'b0;
			state_q <= S_IDLE; step_q <= '0; sat_q <= 1'b0;
			d_in_q <= '0; e_in_q <= '0; g_in_q <= '0; last_in_q <= 1'b0;
			conc_q <= '0; drag_q <= '0;
			for (int i = 0; i < 8; i++) r_q[i] <= '0;
		end else begin
			if (wen && paddr[2:0] == 3'd0) begin
				unique case (widx)
					REG_VEL: vel_q <= pwdata;
					REG_WID: wid_q <= pwdata[62:0];
					REG_BULK: bulk_q <= pwdata;
					REG_C0: c0_q <= pwdata;
					REG_C1: c1_q <= pwdata;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						d_in_q <= in_ch.diffusivity;
						e_in_q <= in_ch.energy;
						g_in_q <= in_ch.gradient;
						last_in_q <= in_ch.is_last;
						drag_q <= '0;
						sat_q <= 1'b0;
						state_q <= S_RUN;
						if (phase_q == 2'd2) begin
							step_q <= 5'd0;
						end else begin
							conc_q <= (phase_q == 2'd0) ? c0_q : c1_q;
							step_q <= 5'd19;
						end
					end
				end
				S_RUN: begin
					if (skip) begin
						if (step_q >= 5'd23) state_q <= S_OUT;
						else step_q <= step_q + 5'd1;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (rsp.done) begin
						sat_q <= sat_q | rsp.sat;
						unique case (step_q)
							5'd0, 5'd1: r_q[0] <= rsp.res;
							5'd2: r_q[1] <= rsp.res;
							5'd3, 5'd4: r_q[2] <= rsp.res;
							5'd5: r_q[3] <= rsp.res;
							5'd6, 5'd7, 5'd8, 5'd17: r_q[4] <= rsp.res;
							5'd9, 5'd10, 5'd11, 5'd13, 5'd14: r_q[5] <= rsp.res;
							5'd12, 5'd15, 5'd16: r_q[6] <= rsp.res;
							5'd18: conc_q <= rsp.res;
							5'd19, 5'd20, 5'd22: r_q[7] <= rsp.res;
							5'd21: sum_q <= rsp.res;
							5'd23: drag_q <= rsp.res;
							default: ;
						endcase
						if (step_q >= 5'd23) state_q <= S_OUT;
						else begin
							step_q <= step_q + 5'd1;
							state_q <= S_RUN;
						end
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
						if (last_in_q) begin
							e1_q <= '0; e2_q <= '0; c1b_q <= '0; c2b_q <= '0; sum_q <= '0;
							d1_q <= '0; d2_q <= '0; phase_q <= '0; ovf_q <= 1'b0;
						end else begin
							e2_q <= e1_q; e1_q <= e_in_q;
							d2_q <= d1_q; d1_q <= d_in_q;
							c2b_q <= c1b_q; c1b_q <= conc_q;
							if (phase_q != 2'd2) phase_q <= phase_q + 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_WAIT && rsp.done && step_q >= 5'd23) ovf_q <= ovf_q | sat_q | rsp.sat;
			if (state_q == S_RUN && skip && step_q >= 5'd23) ovf_q <= ovf_q | sat_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3) else $error("bad segment phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.done_res) |-> out_ch.drag == 64'd0) else $error("drag off last");
endmodule
